>>> sv/threshold_feedback_gate_core_macros.svh
// ------------------------------------------------------------------
// threshold_feedback_gate_core_macros.svh
// assertion macros used by the gate core sequencer
// ------------------------------------------------------------------
`ifndef THRESHOLD_FEEDBACK_GATE_CORE_MACROS_SVH
`define THRESHOLD_FEEDBACK_GATE_CORE_MACROS_SVH

// condition must hold in the same cycle
`define TFG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition must hold in the following cycle
`define TFG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tfg_pkg.sv
// ------------------------------------------------------------------
// tfg_pkg
// shared types and constants of the threshold feedback gate core
// ------------------------------------------------------------------
package tfg_pkg;

  // fixed point format of all time and level values
  localparam int VALUE_BITS    = 32;
  localparam int DEF_FRAC_BITS = 16;

  // configuration port
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNAL_MODE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACT_DELAY       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EARLIEST_TIME   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_START    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_END      = 3'd6;

  // input word
  typedef struct packed {
    logic [VALUE_BITS-1:0] sample_time;
    logic [VALUE_BITS-1:0] peak_level;
  } in_item_t;

  // output word
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] selected_signal;
    logic signed [VALUE_BITS-1:0] growth_rate;
    logic                         trigger_latched;
    logic [VALUE_BITS-1:0]        trigger_time;
    logic                         feedback_open;
    logic                         actuator_open;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic diff_en;
    logic load_en;
    logic step_en;
    logic rate_en;
    logic commit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic advance;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/tfg_datapath.sv
// ------------------------------------------------------------------
// tfg_datapath
// config registers, rate divider, trigger latch and output register
// ------------------------------------------------------------------
module tfg_datapath #(
  parameter int FRAC_BITS = tfg_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tfg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tfg_pkg::VALUE_BITS-1:0]      cfg_data,
  input  tfg_pkg::in_item_t                   in_data,
  input  tfg_pkg::dp_cmd_t                    cmd,
  output tfg_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tfg_pkg::out_item_t                  out_data
);
  import tfg_pkg::*;

  localparam int V = VALUE_BITS;
  localparam longint THRESH_RESET_L = ((longint'(2) << FRAC_BITS) + 50) / 100;
  localparam logic [V-1:0] THRESH_RESET = V'(THRESH_RESET_L);
  localparam logic signed [V-1:0] SMAX = {1'b0, {(V-1){1'b1}}};
  localparam logic signed [V-1:0] SMIN = {1'b1, {(V-1){1'b0}}};

  // configuration registers
  logic                fb_en;
  logic                sig_mode;
  logic signed [V-1:0] thresh;
  logic [V-1:0]        act_delay;
  logic [V-1:0]        earliest;
  logic [V-1:0]        win_start;
  logic [V-1:0]        win_end;

  // captured word
  logic [V-1:0] smp_time;
  logic [V-1:0] smp_level;

  // tracking state
  logic                have_prev;
  logic [V-1:0]        prev_time;
  logic [V-1:0]        prev_level;
  logic signed [V-1:0] held_rate;
  logic                fired;
  logic [V-1:0]        fired_time;

  // divider registers
  logic signed [V:0] diff;
  logic [V-1:0]      dt;
  logic [V-1:0]      rem;
  logic [V-1:0]      quo;
  logic              ovf;
  logic              neg;

  // combinational helpers
  logic                advance;
  logic [V:0]          neg_diff;
  logic [V-1:0]        mag;
  logic [V+FRAC_BITS-1:0] scaled;
  logic [FRAC_BITS-1:0]   hi;
  logic [V-1:0]        hi_ext;
  logic [V:0]          r2;
  logic [V:0]          r2_sub;
  logic                ge;
  logic [V-1:0]        quo_neg;
  logic signed [V-1:0] rate_val;
  logic signed [V-1:0] lvl_sig;
  logic signed [V-1:0] signal;
  logic                trig;
  logic                fired_n;
  logic [V-1:0]        ftime_n;
  logic [V:0]          gate_sum;
  logic                fb_gate;
  logic                win;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_en     <= 1'b0;
      sig_mode  <= 1'b0;
      thresh    <= THRESH_RESET;
      act_delay <= '0;
      earliest  <= '0;
      win_start <= '0;
      win_end   <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FEEDBACK_ENABLE: fb_en     <= cfg_data[0];
        CFG_SIGNAL_MODE:     sig_mode  <= cfg_data[0];
        CFG_TRIG_THRESHOLD:  thresh    <= cfg_data;
        CFG_ACT_DELAY:       act_delay <= cfg_data;
        CFG_EARLIEST_TIME:   earliest  <= cfg_data;
        CFG_WINDOW_START:    win_start <= cfg_data;
        CFG_WINDOW_END:      win_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_time  <= in_data.sample_time;
      smp_level <= in_data.peak_level;
    end
  end

  // time advance check against stored pair
  assign advance = have_prev && (smp_time > prev_time);

  // magnitude of level change and overflow precheck
  assign neg_diff = -diff;
  assign mag      = diff[V] ? neg_diff[V-1:0] : diff[V-1:0];
  assign scaled   = {mag, {FRAC_BITS{1'b0}}};
  assign hi       = scaled[V+FRAC_BITS-1:V];
  assign hi_ext   = {{(V-FRAC_BITS){1'b0}}, hi};

  // one restoring divide step
  assign r2     = {rem, quo[V-1]};
  assign ge     = r2 >= {1'b0, dt};
  assign r2_sub = r2 - {1'b0, dt};

  // signed saturated rate from quotient
  assign quo_neg = -quo;
  always_comb begin
    if (ovf) begin
      rate_val = neg ? SMIN : SMAX;
    end else if (neg) begin
      rate_val = quo[V-1] ? SMIN : signed'(quo_neg);
    end else begin
      rate_val = quo[V-1] ? SMAX : signed'(quo);
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      diff <= signed'({1'b0, smp_level}) - signed'({1'b0, prev_level});
      dt   <= smp_time - prev_time;
    end
    if (cmd.load_en) begin
      rem <= hi_ext;
      quo <= scaled[V-1:0];
      ovf <= hi_ext >= dt;
      neg <= diff[V];
    end else if (cmd.step_en) begin
      rem <= ge ? r2_sub[V-1:0] : r2[V-1:0];
      quo <= {quo[V-2:0], ge};
    end
  end

  // signal selection and trigger
  assign lvl_sig  = smp_level[V-1] ? SMAX : signed'(smp_level);
  assign signal   = sig_mode ? held_rate : lvl_sig;
  assign trig     = fb_en && !fired && (smp_time >= earliest) && (signal >= thresh);
  assign fired_n  = fired || trig;
  assign ftime_n  = trig ? smp_time : fired_time;
  assign gate_sum = {1'b0, ftime_n} + {1'b0, act_delay};
  assign fb_gate  = fb_en && fired_n && ({1'b0, smp_time} >= gate_sum);
  assign win      = (smp_time >= win_start) && (smp_time <= win_end);

  // tracking state update
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      prev_time  <= '0;
      prev_level <= '0;
      held_rate  <= '0;
      fired      <= 1'b0;
      fired_time <= '0;
    end else begin
      if (cmd.diff_en && !have_prev) begin
        held_rate <= '0;
      end else if (cmd.rate_en) begin
        held_rate <= rate_val;
      end
      if (cmd.commit) begin
        if (!have_prev || advance) begin
          have_prev  <= 1'b1;
          prev_time  <= smp_time;
          prev_level <= smp_level;
        end
        fired      <= fired_n;
        fired_time <= ftime_n;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.selected_signal <= signal;
      out_data.growth_rate     <= held_rate;
      out_data.trigger_latched <= fired_n;
      out_data.trigger_time    <= fired_n ? ftime_n : '0;
      out_data.feedback_open   <= fb_gate;
      out_data.actuator_open   <= fb_en ? fb_gate : win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.advance  = advance;
  assign status.out_free = !out_valid || out_ready;

endmodule

>>> sv/tfg_ctrl.sv
// ------------------------------------------------------------------
// tfg_ctrl
// sequencer for capture, divide, rate update and result commit
// ------------------------------------------------------------------
`include "threshold_feedback_gate_core_macros.svh"

module tfg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tfg_pkg::dp_status_t status,
  output tfg_pkg::dp_cmd_t    cmd
);
  import tfg_pkg::*;

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST = CW'(VALUE_BITS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIFF = 6'b000010,
    S_LOAD = 6'b000100,
    S_DIV  = 6'b001000,
    S_RATE = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          in_accept;
  logic          div_last;

  // next state and commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = status.advance ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        cmd.load_en = 1'b1;
        count_next  = '0;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.step_en = 1'b1;
        count_next  = count + CW'(1);
        if (count == LAST) state_next = S_RATE;
      end
      S_RATE: begin
        cmd.rate_en = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        cmd.commit = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // assertion helpers
  assign in_accept = in_valid && in_ready;
  assign div_last  = (state == S_DIV) && (count == LAST);

  // result never overwrites a word still waiting
  `TFG_ASSERT_NOW(a_commit_free, clk, rst, cmd.commit, status.out_free, "commit while busy")
  // accepted word starts processing
  `TFG_ASSERT_NEXT(a_accept_diff, clk, rst, in_accept, state == S_DIFF, "no diff after accept")
  // divide ends after the last quotient bit
  `TFG_ASSERT_NEXT(a_div_exit, clk, rst, div_last, state == S_RATE, "divide did not finish")

endmodule

>>> sv/threshold_feedback_gate_core.sv
// Sequence: a word that advances time goes through S_DIFF, S_LOAD, S_DIV, S_RATE and
//   S_DONE after it is accepted; a first word or one that does not advance goes S_DIFF, S_DONE.
// A new word is accepted only in S_IDLE, once the last one is committed; the restoring
//   divider gives one quotient bit per cycle, VALUE_BITS steps per rate.
// Reset (rst, synchronous): config registers to their defaults, tracking state and
//   trigger cleared, output word invalid.
// ------------------------------------------------------------------
// threshold_feedback_gate_core
// growth rate tracker with one-shot threshold trigger and actuator gating
// ------------------------------------------------------------------
module threshold_feedback_gate_core #(
  parameter int FRAC_BITS = tfg_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tfg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tfg_pkg::VALUE_BITS-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tfg_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tfg_pkg::out_item_t               out_data
);
  import tfg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  tfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  tfg_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/tb_threshold_feedback_gate_core.sv
// ------------------------------------------------------------------
// tb_threshold_feedback_gate_core
// self-checking bench for the threshold feedback gate core: words with
// random gaps and stalls go through the block, a local predictor of the
// rate tracker, the one-shot trigger and the gates checks every result
// ------------------------------------------------------------------
module tb_threshold_feedback_gate_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tfg_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int FRAC = DEF_FRAC_BITS;
  localparam logic [VB-1:0] ALL_ONES = {VB{1'b1}};
  localparam logic [VB-1:0] SMAX_V = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] SMIN_V = {1'b1, {(VB-1){1'b0}}};
  // 0.02 in Q16.16, rounded
  localparam logic [VB-1:0] THRESH_AT_RESET = 32'd1311;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REGISTER = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT = 5000;
  localparam int LONG_HOLD_OFF = 400;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [VB-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  threshold_feedback_gate_core #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // predictor copy of the registers
  logic fb_on, mode_rate;
  logic [VB-1:0] thresh, act_delay, earliest_t, win_open, win_close;

  // predictor copy of the tracking state
  logic seen_first, latched;
  logic [VB-1:0] last_time, last_level, rate_now, latch_time;

  out_item_t expected_words[$];

  // stimulus cursor and handshake controls
  logic [VB-1:0] stim_time, stim_level;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_off_request = 0;

  int words_sent = 0;
  int words_checked = 0;
  int rate_updates = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // (level << FRAC) / dt, truncated toward zero, saturated to signed VB bits
  function automatic logic [VB-1:0] divide_rate(longint diff, longint unsigned dt);
    longint unsigned mag, quo, rem, cap, neg_q;
    int i;
    cap = 64'd1 << VB;
    mag = (diff < 0) ? -diff : diff;
    quo = mag / dt;
    rem = mag % dt;
    if (quo > cap) quo = cap;
    for (i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= dt) begin
        rem = rem - dt;
        quo = quo | 64'd1;
      end
      if (quo > cap) quo = cap;
    end
    if (diff < 0) begin
      if (quo >= (cap >> 1)) return SMIN_V;
      neg_q = 64'd0 - quo;
      return neg_q[VB-1:0];
    end
    if (quo >= (cap >> 1)) return SMAX_V;
    return quo[VB-1:0];
  endfunction

  // expected result word for one accepted input word
  function automatic out_item_t predict_gate(in_item_t w);
    out_item_t res;
    logic [VB-1:0] t, lvl, sig;
    longint lvl_wide, prev_wide;
    logic fb_gate, in_window;
    t = w.sample_time;
    lvl = w.peak_level;
    if (!seen_first) begin
      seen_first = 1'b1;
      last_time = t;
      last_level = lvl;
      rate_now = '0;
    end else if (t > last_time) begin
      lvl_wide = lvl;
      prev_wide = last_level;
      rate_now = divide_rate(lvl_wide - prev_wide, t - last_time);
      last_time = t;
      last_level = lvl;
      rate_updates++;
    end
    sig = mode_rate ? rate_now : (lvl[VB-1] ? SMAX_V : lvl);
    if (fb_on && !latched && t >= earliest_t && $signed(sig) >= $signed(thresh)) begin
      latched = 1'b1;
      latch_time = t;
    end
    // trigger time plus delay one bit wider, so it never wraps
    fb_gate = fb_on && latched && ({1'b0, t} >= ({1'b0, latch_time} + {1'b0, act_delay}));
    in_window = (t >= win_open) && (t <= win_close);
    res.selected_signal = sig;
    res.growth_rate = rate_now;
    res.trigger_latched = latched;
    res.trigger_time = latched ? latch_time : '0;
    res.feedback_open = fb_gate;
    res.actuator_open = fb_on ? fb_gate : in_window;
    return res;
  endfunction

  task automatic check_field(string name, logic [VB-1:0] exp_v, logic [VB-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t exp_w;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("result word %h with nothing expected", out_data);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        check_field("selected_signal", exp_w.selected_signal, out_data.selected_signal);
        check_field("growth_rate", exp_w.growth_rate, out_data.growth_rate);
        check_field("trigger_latched", exp_w.trigger_latched, out_data.trigger_latched);
        check_field("trigger_time", exp_w.trigger_time, out_data.trigger_time);
        check_field("feedback_open", exp_w.feedback_open, out_data.feedback_open);
        check_field("actuator_open", exp_w.actuator_open, out_data.actuator_open);
      end
    end
  end

  // result sink: random stall before each word while receiver_idles is set, long hold-off on request
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_request > 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
      end else begin
        stall = receiver_idles ? $urandom_range(0, 16) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // offer one word and record its expected result on acceptance
  task automatic send_word(in_item_t w);
    int gap;
    gap = sender_idles ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_words.push_back(predict_gate(w));
    words_sent++;
  endtask

  task automatic send_pair(logic [VB-1:0] t, logic [VB-1:0] lvl);
    in_item_t w;
    w.sample_time = t;
    w.peak_level = lvl;
    send_word(w);
  endtask

  // drop valid and wait until every expected word has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [VB-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_FEEDBACK_ENABLE: fb_on = val[0];
      CFG_SIGNAL_MODE:     mode_rate = val[0];
      CFG_TRIG_THRESHOLD:  thresh = val;
      CFG_ACT_DELAY:       act_delay = val;
      CFG_EARLIEST_TIME:   earliest_t = val;
      CFG_WINDOW_START:    win_open = val;
      CFG_WINDOW_END:      win_close = val;
      default: ;
    endcase
  endtask

  function automatic logic [VB-1:0] random_threshold();
    case ($urandom_range(0, 3))
      0: return SMIN_V;
      1: return SMAX_V;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_random_window(int shape);
    logic [VB-1:0] a, b, tmp;
    case (shape)
      0: begin a = '0; b = ALL_ONES; end
      1: begin a = '0; b = '0; end
      2: begin a = ALL_ONES; b = ALL_ONES; end
      3: begin a = ALL_ONES; b = '0; end
      default: begin
        a = $urandom;
        b = $urandom;
        if (a > b) begin
          tmp = a;
          a = b;
          b = tmp;
        end
      end
    endcase
    write_reg(CFG_WINDOW_START, a);
    write_reg(CFG_WINDOW_END, b);
  endtask

  // mostly advancing time with a wandering level, some equal, backward
  // and fully random words mixed in
  function automatic in_item_t next_word();
    in_item_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) stim_time = stim_time + $urandom_range(1, 32'h3FFFF);
    else if (pick < 55) stim_time = stim_time + $urandom_range(1, 255);
    else if (pick < 65) stim_time = stim_time + $urandom;
    else if (pick < 78) stim_time = stim_time;
    else if (pick < 88) stim_time = stim_time - $urandom_range(1, 32'hFFFF);
    else stim_time = $urandom;
    case ($urandom_range(0, 9))
      0: stim_level = '0;
      1: stim_level = ALL_ONES;
      2, 3: stim_level = $urandom;
      default: stim_level = stim_level + $urandom_range(0, 32'h3FFFF) - 32'h20000;
    endcase
    w.sample_time = stim_time;
    w.peak_level = stim_level;
    return w;
  endfunction

  // first word after reset, equal and earlier times with reset settings
  task automatic test_reset_state();
    send_pair(32'h0000_0100, SMIN_V);
    send_pair(32'h0000_0100, 32'h0000_0010);
    send_pair(32'h0000_0080, 32'h0000_0020);
    send_pair(32'h0000_0200, 32'h0000_0000);
  endtask

  // rate saturation both ways, truncation, hold and a huge time step
  task automatic test_rate_extremes();
    wait_idle();
    write_reg(CFG_SIGNAL_MODE, 32'd1);
    write_reg(CFG_NO_REGISTER, ALL_ONES);
    send_pair(32'h0000_1000, 32'h0000_0000);
    send_pair(32'h0000_1001, ALL_ONES);
    send_pair(32'h0000_1002, 32'h0000_0000);
    send_pair(32'h0000_1005, ALL_ONES);
    send_pair(32'h0000_1008, 32'hFFFF_FFFE);
    send_pair(32'h0000_1008, 32'h0000_0005);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0001_1008, 32'hFFFF_FFFE);
    send_pair(ALL_ONES, 32'h1234_5678);
  endtask

  // inclusive window edges and an inverted window
  task automatic test_window_edges();
    wait_idle();
    write_reg(CFG_SIGNAL_MODE, 32'd0);
    write_reg(CFG_WINDOW_START, 32'h0000_5000);
    write_reg(CFG_WINDOW_END, 32'h0000_5000);
    send_pair(32'h0000_4FFF, 32'h0000_0001);
    send_pair(32'h0000_5000, 32'h0000_0002);
    send_pair(32'h0000_5001, 32'h0000_0003);
    wait_idle();
    write_random_window(3);
    send_pair(32'h0000_0000, 32'h0000_0004);
    send_pair(ALL_ONES, 32'h0000_0005);
  endtask

  // time-window gating with random settings
  task automatic test_window_random();
    int k, n;
    for (k = 0; k < 6; k++) begin
      wait_idle();
      sender_idles = (k % 4 != 3);
      receiver_idles = (k % 3 != 2);
      write_reg(CFG_FEEDBACK_ENABLE, 32'd0);
      write_reg(CFG_SIGNAL_MODE, k % 2);
      write_reg(CFG_TRIG_THRESHOLD, random_threshold());
      write_random_window(k < 4 ? k : 4);
      for (n = 0; n < 100; n++) send_word(next_word());
    end
  endtask

  // feedback enabled but the earliest time keeps the trigger from latching
  task automatic test_armed_quiet();
    in_item_t w;
    int k, n;
    for (k = 0; k < 3; k++) begin
      wait_idle();
      sender_idles = (k != 1);
      receiver_idles = (k != 2);
      write_reg(CFG_EARLIEST_TIME, ALL_ONES);
      write_reg(CFG_FEEDBACK_ENABLE, 32'd1);
      write_reg(CFG_SIGNAL_MODE, $urandom_range(0, 1));
      write_reg(CFG_TRIG_THRESHOLD, random_threshold());
      write_reg(CFG_ACT_DELAY, $urandom);
      for (n = 0; n < 100; n++) begin
        w = next_word();
        if (w.sample_time == ALL_ONES) w.sample_time = ALL_ONES - 1;
        send_word(w);
      end
    end
  endtask

  // one-shot trigger: too early, below threshold, exactly at threshold,
  // then the delay boundary, a delay that would wrap, and disable
  task automatic test_trigger_fire();
    wait_idle();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    write_reg(CFG_SIGNAL_MODE, 32'd0);
    write_reg(CFG_TRIG_THRESHOLD, 32'h0005_0000);
    write_reg(CFG_EARLIEST_TIME, 32'h0010_0000);
    write_reg(CFG_ACT_DELAY, 32'h0002_0000);
    send_pair(32'h000F_0000, 32'h0010_0000);
    send_pair(32'h0010_0000, 32'h0004_0000);
    send_pair(32'h0010_8000, 32'h0005_0000);
    send_pair(32'h0012_0000, 32'h0000_0000);
    send_pair(32'h0012_8000, 32'h0000_0000);
    send_pair(32'h0012_7FFF, 32'h0009_0000);
    wait_idle();
    write_reg(CFG_ACT_DELAY, ALL_ONES);
    send_pair(ALL_ONES, 32'h0000_0000);
    wait_idle();
    write_reg(CFG_ACT_DELAY, 32'd0);
    send_pair(32'h0010_8000, 32'h0000_0000);
    wait_idle();
    write_reg(CFG_FEEDBACK_ENABLE, 32'd0);
    write_random_window(0);
    send_pair(32'h0010_8000, 32'h0000_0000);
  endtask

  // everything random once the trigger is latched
  task automatic test_latched_random();
    int k, n;
    for (k = 0; k < 8; k++) begin
      wait_idle();
      sender_idles = (k % 4 != 1);
      receiver_idles = (k % 3 != 0);
      write_reg(CFG_FEEDBACK_ENABLE, k % 2);
      write_reg(CFG_SIGNAL_MODE, $urandom_range(0, 1));
      write_reg(CFG_TRIG_THRESHOLD, random_threshold());
      case ($urandom_range(0, 3))
        0: write_reg(CFG_ACT_DELAY, 32'd0);
        1: write_reg(CFG_ACT_DELAY, ALL_ONES);
        2: write_reg(CFG_ACT_DELAY, $urandom_range(0, 32'hFFFFF));
        default: write_reg(CFG_ACT_DELAY, $urandom);
      endcase
      write_reg(CFG_EARLIEST_TIME, (k % 3 == 0) ? 32'd0 : $urandom);
      write_random_window($urandom_range(0, 7));
      for (n = 0; n < 100; n++) send_word(next_word());
    end
  endtask

  // sink holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    int n;
    wait_idle();
    sender_idles = 1'b0;
    receiver_idles = 1'b1;
    hold_off_request = LONG_HOLD_OFF;
    for (n = 0; n < 24; n++) send_word(next_word());
    sender_idles = 1'b1;
  endtask

  initial begin
    int waited;
    fb_on = 1'b0;
    mode_rate = 1'b0;
    thresh = THRESH_AT_RESET;
    act_delay = '0;
    earliest_t = '0;
    win_open = '0;
    win_close = ALL_ONES;
    seen_first = 1'b0;
    latched = 1'b0;
    last_time = '0;
    last_level = '0;
    rate_now = '0;
    latch_time = '0;
    stim_time = '0;
    stim_level = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_rate_extremes();
    test_window_edges();
    test_window_random();
    test_armed_quiet();
    test_trigger_fire();
    test_latched_random();
    test_output_backpressure();

    // drain with a bound, then allow for stray words
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      fail_count++;
    end

    $display("run: %0d words in, %0d results checked, %0d rate updates, %0d cycles",
             words_sent, words_checked, rate_updates, cycle_count);
    $display("trigger latched: %0b at time %h, mismatches: %0d",
             latched, latch_time, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
